// ===== rtl/core/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg
// Widths, stage transfer structs and helpers for the segment intersection test.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_WIDTH-1:0]  t_diff;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;
    typedef logic signed [SUM_WIDTH-1:0]   t_sum;

    // differences: u = P4-P3, v = P2-P1, a1 = P3-P1, a2 = P3-P2, a4 = P4-P1, b2 = P4-P2
    typedef struct packed {
        logic       func;
        logic [3:0] in_box;   // P3 in box P1P2, P4 in box P1P2, P1 in box P3P4, P2 in box P3P4
        t_diff      ux, uy, vx, vy;
        t_diff      a1x, a1y, a2x, a2y, a4x, a4y, b2x, b2y;
    } t_diffs;

    typedef struct packed {
        logic       func;
        logic [3:0] in_box;
        t_prod      d1p, d1q, d2p, d2q, d3p, d3q, d4p, d4q;
        t_prod      e1p, e1q, e2p, e2q, e3p, e3q, e4p, e4q;
    } t_prods;

    typedef struct packed {
        logic       func;
        logic [3:0] in_box;
        logic [3:0] det_neg;
        logic [3:0] det_zero;
        logic [3:0] dot_neg;
    } t_signs;

    function automatic logic between(input t_coord p, input t_coord e0, input t_coord e1);
        between = ((p >= e0) && (p <= e1)) || ((p >= e1) && (p <= e0));
    endfunction

    function automatic logic opposite(input logic n0, input logic z0,
                                      input logic n1, input logic z1);
        opposite = (n0 && !n1 && !z1) || (n1 && !n0 && !z0);
    endfunction

endpackage

// ===== rtl/core/sit_diff_stage.sv =====
// ----------------------------------------------------------------------------
// sit_diff_stage
// Stage 1: coordinate differences and bounding box checks.
// ----------------------------------------------------------------------------
module sit_diff_stage import sit_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  logic   i_func,
    input  t_coord i_x1,
    input  t_coord i_y1,
    input  t_coord i_x2,
    input  t_coord i_y2,
    input  t_coord i_x3,
    input  t_coord i_y3,
    input  t_coord i_x4,
    input  t_coord i_y4,
    output logic   o_valid,
    input  logic   i_ready,
    output t_diffs o_data
);

    logic   r_valid;
    t_diffs r_data;
    t_diffs n_data;

    always_comb begin
        n_data.func      = i_func;
        n_data.in_box[0] = between(i_x3, i_x1, i_x2) && between(i_y3, i_y1, i_y2);
        n_data.in_box[1] = between(i_x4, i_x1, i_x2) && between(i_y4, i_y1, i_y2);
        n_data.in_box[2] = between(i_x1, i_x3, i_x4) && between(i_y1, i_y3, i_y4);
        n_data.in_box[3] = between(i_x2, i_x3, i_x4) && between(i_y2, i_y3, i_y4);
        n_data.ux  = t_diff'(i_x4) - t_diff'(i_x3);
        n_data.uy  = t_diff'(i_y4) - t_diff'(i_y3);
        n_data.vx  = t_diff'(i_x2) - t_diff'(i_x1);
        n_data.vy  = t_diff'(i_y2) - t_diff'(i_y1);
        n_data.a1x = t_diff'(i_x3) - t_diff'(i_x1);
        n_data.a1y = t_diff'(i_y3) - t_diff'(i_y1);
        n_data.a2x = t_diff'(i_x3) - t_diff'(i_x2);
        n_data.a2y = t_diff'(i_y3) - t_diff'(i_y2);
        n_data.a4x = t_diff'(i_x4) - t_diff'(i_x1);
        n_data.a4y = t_diff'(i_y4) - t_diff'(i_y1);
        n_data.b2x = t_diff'(i_x4) - t_diff'(i_x2);
        n_data.b2y = t_diff'(i_y4) - t_diff'(i_y2);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/sit_prod_stage.sv =====
// ----------------------------------------------------------------------------
// sit_prod_stage
// Stage 2: the sixteen partial products of the determinants and dot products.
// ----------------------------------------------------------------------------
module sit_prod_stage import sit_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_diffs i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_prods o_data
);

    logic   r_valid;
    t_prods r_data;
    t_prods n_data;

    always_comb begin
        n_data.func   = i_data.func;
        n_data.in_box = i_data.in_box;
        // d = p - q
        n_data.d1p = t_prod'(i_data.ux) * t_prod'(i_data.a1y);
        n_data.d1q = t_prod'(i_data.uy) * t_prod'(i_data.a1x);
        n_data.d2p = t_prod'(i_data.ux) * t_prod'(i_data.a2y);
        n_data.d2q = t_prod'(i_data.uy) * t_prod'(i_data.a2x);
        n_data.d3p = t_prod'(i_data.vx) * t_prod'(i_data.a1y);
        n_data.d3q = t_prod'(i_data.vy) * t_prod'(i_data.a1x);
        n_data.d4p = t_prod'(i_data.vx) * t_prod'(i_data.a4y);
        n_data.d4q = t_prod'(i_data.vy) * t_prod'(i_data.a4x);
        // dot = p + q
        n_data.e1p = t_prod'(i_data.a1x) * t_prod'(i_data.a4x);
        n_data.e1q = t_prod'(i_data.a1y) * t_prod'(i_data.a4y);
        n_data.e2p = t_prod'(i_data.a2x) * t_prod'(i_data.b2x);
        n_data.e2q = t_prod'(i_data.a2y) * t_prod'(i_data.b2y);
        n_data.e3p = t_prod'(i_data.a1x) * t_prod'(i_data.a2x);
        n_data.e3q = t_prod'(i_data.a1y) * t_prod'(i_data.a2y);
        n_data.e4p = t_prod'(i_data.a4x) * t_prod'(i_data.b2x);
        n_data.e4q = t_prod'(i_data.a4y) * t_prod'(i_data.b2y);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/sit_sign_stage.sv =====
// ----------------------------------------------------------------------------
// sit_sign_stage
// Stage 3: sums of the product pairs, reduced to sign and zero flags.
// ----------------------------------------------------------------------------
module sit_sign_stage import sit_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_prods i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_signs o_data
);

    logic   r_valid;
    t_signs r_data;
    t_signs n_data;
    t_sum   det [4];
    t_sum   dot [4];

    always_comb begin
        det[0] = t_sum'(i_data.d1p) - t_sum'(i_data.d1q);
        det[1] = t_sum'(i_data.d2p) - t_sum'(i_data.d2q);
        det[2] = t_sum'(i_data.d3p) - t_sum'(i_data.d3q);
        det[3] = t_sum'(i_data.d4p) - t_sum'(i_data.d4q);
        dot[0] = t_sum'(i_data.e1p) + t_sum'(i_data.e1q);
        dot[1] = t_sum'(i_data.e2p) + t_sum'(i_data.e2q);
        dot[2] = t_sum'(i_data.e3p) + t_sum'(i_data.e3q);
        dot[3] = t_sum'(i_data.e4p) + t_sum'(i_data.e4q);
        n_data.func   = i_data.func;
        n_data.in_box = i_data.in_box;
        for (int k = 0; k < 4; k++) begin
            n_data.det_neg[k]  = det[k][SUM_WIDTH-1];
            n_data.det_zero[k] = (det[k] == '0);
            n_data.dot_neg[k]  = dot[k][SUM_WIDTH-1];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/sit_decide_stage.sv =====
// ----------------------------------------------------------------------------
// sit_decide_stage
// Stage 4: crossing, collinear overlap and endpoint touch rules; output register.
// ----------------------------------------------------------------------------
module sit_decide_stage import sit_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_signs i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output logic   o_hit
);

    logic r_valid;
    logic r_hit;
    logic n_hit;
    logic crossing;
    logic overlap;
    logic touch;

    always_comb begin
        crossing = opposite(i_data.det_neg[0], i_data.det_zero[0],
                            i_data.det_neg[1], i_data.det_zero[1])
                && opposite(i_data.det_neg[2], i_data.det_zero[2],
                            i_data.det_neg[3], i_data.det_zero[3]);
        overlap  = (&i_data.det_zero) && (|i_data.dot_neg);
        // P3, P4 test against d3, d4; P1, P2 against d1, d2
        touch    = (i_data.in_box[0] && i_data.det_zero[2])
                || (i_data.in_box[1] && i_data.det_zero[3])
                || (i_data.in_box[2] && i_data.det_zero[0])
                || (i_data.in_box[3] && i_data.det_zero[1]);
        n_hit    = crossing || (i_data.func ? overlap : touch);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_hit <= n_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

// ===== rtl/core/segment_intersection_test_top.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_test_top
// Orientation test of two integer line segments, four register stages.
// ----------------------------------------------------------------------------
// channel | handshake                 | payload
// input   | i_in_valid / o_in_ready   | i_func, i_first_*, i_second_*
// output  | o_out_valid / i_out_ready | o_intersects
//
// One segment pair per cycle while the output is not stalled; each result passes
// through the registered chain in order: differences, multipliers, wide add and sign, rules.
// Synchronous active-low reset empties all stages; no state between items.
// A stall fills the empty stages first, then holds every stage in place.
// ----------------------------------------------------------------------------
module segment_intersection_test_top import sit_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  logic   i_func,
    input  t_coord i_first_start_x,
    input  t_coord i_first_start_y,
    input  t_coord i_first_end_x,
    input  t_coord i_first_end_y,
    input  t_coord i_second_start_x,
    input  t_coord i_second_start_y,
    input  t_coord i_second_end_x,
    input  t_coord i_second_end_y,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output logic   o_intersects
);

    logic   s1_valid, s1_ready;
    logic   s2_valid, s2_ready;
    logic   s3_valid, s3_ready;
    t_diffs s1_data;
    t_prods s2_data;
    t_signs s3_data;

    sit_diff_stage u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_func  (i_func),
        .i_x1    (i_first_start_x),
        .i_y1    (i_first_start_y),
        .i_x2    (i_first_end_x),
        .i_y2    (i_first_end_y),
        .i_x3    (i_second_start_x),
        .i_y3    (i_second_start_y),
        .i_x4    (i_second_end_x),
        .i_y4    (i_second_end_y),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    sit_prod_stage u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    sit_sign_stage u_sign (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_data  (s3_data)
    );

    sit_decide_stage u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_data  (s3_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_hit   (o_intersects)
    );

`ifndef NO_ASSERTIONS
    // an empty output stage lets the whole chain advance
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready with output stage empty");

    // a full, stalled pipeline takes no transfer
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && s2_valid && s3_valid && o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("transfer taken while every stage is full and stalled");

    // an accepted item always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> s1_valid)
        else $error("accepted item lost at first stage");
`endif

endmodule

// ===== sim/segment_intersection_checker.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_checker
// Watches both channels of the segment intersection test, predicts the
// flag of every accepted segment pair and compares it with the result that
// comes out, in order.
// ----------------------------------------------------------------------------
module segment_intersection_checker import sit_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_ready,
    input  logic   i_func,
    input  t_coord i_first_start_x,
    input  t_coord i_first_start_y,
    input  t_coord i_first_end_x,
    input  t_coord i_first_end_y,
    input  t_coord i_second_start_x,
    input  t_coord i_second_start_y,
    input  t_coord i_second_end_x,
    input  t_coord i_second_end_y,
    input  logic   i_out_valid,
    input  logic   i_out_ready,
    input  logic   i_intersects,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_checked,
    output int     o_hits
);

    bit predicted_hits[$];
    int fails   = 0;
    int checked = 0;
    int hits    = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_hits       = 0;
    end

    function automatic int sign_of(input longint v);
        return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
    endfunction

    function automatic int cross_sign(input longint ax, ay, bx, by);
        return sign_of(ax * by - ay * bx);
    endfunction

    function automatic bit dot_negative(input longint ax, ay, bx, by);
        return (ax * bx + ay * by) < 0;
    endfunction

    // inclusive bounding box, then on the line
    function automatic bit point_on_segment(input longint x1, y1, x2, y2, px, py);
        longint xl, xh, yl, yh;
        xl = (x1 < x2) ? x1 : x2;
        xh = (x1 < x2) ? x2 : x1;
        yl = (y1 < y2) ? y1 : y2;
        yh = (y1 < y2) ? y2 : y1;
        if (px < xl || px > xh || py < yl || py > yh) begin
            return 1'b0;
        end
        return cross_sign(x2 - x1, y2 - y1, px - x1, py - y1) == 0;
    endfunction

    function automatic bit segment_pair_hit(input bit mode,
                                            input longint x1, y1, x2, y2,
                                            input longint x3, y3, x4, y4);
        int s1, s2, s3, s4;
        bit hit;
        s1 = cross_sign(x4 - x3, y4 - y3, x3 - x1, y3 - y1);
        s2 = cross_sign(x4 - x3, y4 - y3, x3 - x2, y3 - y2);
        s3 = cross_sign(x2 - x1, y2 - y1, x3 - x1, y3 - y1);
        s4 = cross_sign(x2 - x1, y2 - y1, x4 - x1, y4 - y1);
        if (s1 * s2 < 0 && s3 * s4 < 0) begin
            hit = 1'b1;
        end else if (mode) begin
            hit = (s1 == 0 && s2 == 0 && s3 == 0 && s4 == 0)
               && (dot_negative(x3 - x1, y3 - y1, x4 - x1, y4 - y1)
                || dot_negative(x3 - x2, y3 - y2, x4 - x2, y4 - y2)
                || dot_negative(x1 - x3, y1 - y3, x2 - x3, y2 - y3)
                || dot_negative(x1 - x4, y1 - y4, x2 - x4, y2 - y4));
        end else begin
            hit = point_on_segment(x1, y1, x2, y2, x3, y3)
               || point_on_segment(x1, y1, x2, y2, x4, y4)
               || point_on_segment(x3, y3, x4, y4, x1, y1)
               || point_on_segment(x3, y3, x4, y4, x2, y2);
        end
        return hit;
    endfunction

    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                predicted_hits.push_back(segment_pair_hit(i_func,
                    i_first_start_x, i_first_start_y, i_first_end_x, i_first_end_y,
                    i_second_start_x, i_second_start_y, i_second_end_x, i_second_end_y));
            end
            if (i_out_valid && i_out_ready) begin
                if (predicted_hits.size() == 0) begin
                    $error("intersects: result %0b with no transfer awaiting it",
                           i_intersects);
                    fails++;
                end else begin
                    want = predicted_hits.pop_front();
                    checked++;
                    if (i_intersects === 1'b1) begin
                        hits++;
                    end
                    if (i_intersects !== want) begin
                        $error("intersects: expected %0b, actual %0b", want, i_intersects);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= predicted_hits.size();
        o_checked    <= checked;
        o_hits       <= hits;
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives segment pairs into the segment intersection test: a directed set of
// crossings, touches, collinear and degenerate cases at the coordinate
// extremes, then random pairs biased towards collinear and touching shapes.
// Both channels stall in random bursts; the checker gives the failure count.
// ----------------------------------------------------------------------------
module testbench;
    import sit_pkg::*;

    localparam int RANDOM_PAIRS   = 1200;
    localparam int QUIET_TAIL     = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 16;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_ready;
    logic   i_func;
    t_coord i_first_start_x;
    t_coord i_first_start_y;
    t_coord i_first_end_x;
    t_coord i_first_end_y;
    t_coord i_second_start_x;
    t_coord i_second_start_y;
    t_coord i_second_end_x;
    t_coord i_second_end_y;
    logic   o_out_valid;
    logic   i_out_ready;
    logic   o_intersects;

    int fail_count;
    int pending;
    int checked;
    int hits;
    int pairs_sent;
    int directed_pairs;
    int idle_cycles;
    int stall_left;
    bit was_stalled;
    bit quiet;

    segment_intersection_test_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_first_start_x  (i_first_start_x),
        .i_first_start_y  (i_first_start_y),
        .i_first_end_x    (i_first_end_x),
        .i_first_end_y    (i_first_end_y),
        .i_second_start_x (i_second_start_x),
        .i_second_start_y (i_second_start_y),
        .i_second_end_x   (i_second_end_x),
        .i_second_end_y   (i_second_end_y),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_intersects     (o_intersects)
    );

    segment_intersection_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_first_start_x  (i_first_start_x),
        .i_first_start_y  (i_first_start_y),
        .i_first_end_x    (i_first_end_x),
        .i_first_end_y    (i_first_end_y),
        .i_second_start_x (i_second_start_x),
        .i_second_start_y (i_second_start_y),
        .i_second_end_x   (i_second_end_x),
        .i_second_end_y   (i_second_end_y),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_intersects     (o_intersects),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_hits           (hits)
    );

    always #5 i_clk = ~i_clk;

    // receiver back-pressure: random bursts, never back to back
    always @(posedge i_clk) begin
        bit rdy;
        if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (!quiet && !was_stalled && i_rst_n && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        was_stalled = !rdy;
        i_out_ready <= rdy;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // order: x1, y1, x2, y2, x3, y3, x4, y4
    task automatic send_pair(input logic f, input t_coord p [8]);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_func           <= f;
        i_first_start_x  <= p[0];
        i_first_start_y  <= p[1];
        i_first_end_x    <= p[2];
        i_first_end_y    <= p[3];
        i_second_start_x <= p[4];
        i_second_start_y <= p[5];
        i_second_end_x   <= p[6];
        i_second_end_y   <= p[7];
        i_in_valid       <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pairs_sent++;
    endtask

    function automatic t_coord extreme_coord();
        case ($urandom_range(0, 6))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            5: return 16'sd32766;
            default: return 16'sd32767;
        endcase
    endfunction

    function automatic int span(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic send_random_pair();
        t_coord p [8];
        int bx, by, dx, dy, m, j;
        bx = span(-1000, 1000);
        by = span(-1000, 1000);
        dx = span(-40, 40);
        dy = span(-40, 40);
        case ($urandom_range(0, 9))
            0, 1: begin
                foreach (p[i]) p[i] = t_coord'($urandom_range(0, 65535));
            end
            2: begin
                foreach (p[i]) p[i] = extreme_coord();
            end
            3: begin
                foreach (p[i]) p[i] = t_coord'(span(-4, 4));
            end
            4, 5: begin
                // all four points on one line
                if ($urandom_range(0, 3) == 0) begin
                    bx = 0;
                    by = 0;
                    dx = span(-1000, 1000);
                    dy = span(-1000, 1000);
                    m  = 32;
                end else begin
                    m = 20;
                end
                for (int i = 0; i < 4; i++) begin
                    j = span(-m, m);
                    p[2*i]   = t_coord'(bx + j * dx);
                    p[2*i+1] = t_coord'(by + j * dy);
                end
            end
            6: begin
                // shared endpoint
                foreach (p[i]) p[i] = t_coord'(span(-2000, 2000));
                j = 2 * $urandom_range(0, 1);
                p[4] = p[j];
                p[5] = p[j+1];
                if ($urandom_range(0, 1)) begin
                    {p[4], p[5], p[6], p[7]} = {p[6], p[7], p[4], p[5]};
                end
            end
            7: begin
                // endpoint of the second segment on the first
                m = span(2, 20);
                j = span(0, m);
                p[0] = t_coord'(bx);
                p[1] = t_coord'(by);
                p[2] = t_coord'(bx + m * dx);
                p[3] = t_coord'(by + m * dy);
                p[4] = t_coord'(bx + j * dx);
                p[5] = t_coord'(by + j * dy);
                p[6] = t_coord'(bx + span(-50, 50));
                p[7] = t_coord'(by + span(-50, 50));
            end
            8: begin
                // degenerate segments, point often on the other line
                j = span(-3, 23);
                p[0] = t_coord'(bx + j * dx);
                p[1] = t_coord'(by + j * dy);
                p[2] = p[0];
                p[3] = p[1];
                p[4] = t_coord'(bx);
                p[5] = t_coord'(by);
                if ($urandom_range(0, 2) == 0) begin
                    p[6] = p[4];
                    p[7] = p[5];
                end else begin
                    p[6] = t_coord'(bx + 20 * dx);
                    p[7] = t_coord'(by + 20 * dy);
                end
                if ($urandom_range(0, 3) == 0) begin
                    p[1] = t_coord'(p[1] + 1);
                    p[3] = p[1];
                end
            end
            default: begin
                foreach (p[i]) p[i] = t_coord'(span(-100, 100));
            end
        endcase
        send_pair(1'($urandom_range(0, 1)), p);
    endtask

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_out_ready      = 1'b0;
        i_func           = 1'b0;
        i_first_start_x  = '0;
        i_first_start_y  = '0;
        i_first_end_x    = '0;
        i_first_end_y    = '0;
        i_second_start_x = '0;
        i_second_start_y = '0;
        i_second_end_x   = '0;
        i_second_end_y   = '0;
        pairs_sent       = 0;
        idle_cycles      = 0;
        stall_left       = 0;
        was_stalled      = 1'b0;
        quiet            = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // proper crossing, centre and full range
        send_pair(1'b0, '{-10, -10, 10, 10, -10, 10, 10, -10});
        send_pair(1'b1, '{-10, -10, 10, 10, -10, 10, 10, -10});
        send_pair(1'b0, '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768});
        send_pair(1'b1, '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768});
        // parallel, apart
        send_pair(1'b1, '{0, 0, 10, 0, 0, 1, 10, 1});
        // collinear: overlap, disjoint, touching at an end only
        send_pair(1'b0, '{0, 0, 10, 0, 5, 0, 15, 0});
        send_pair(1'b1, '{0, 0, 10, 0, 5, 0, 15, 0});
        send_pair(1'b0, '{0, 0, 4, 4, 5, 5, 9, 9});
        send_pair(1'b1, '{0, 0, 4, 4, 5, 5, 9, 9});
        send_pair(1'b0, '{0, 0, 5, 5, 5, 5, 9, 9});
        send_pair(1'b1, '{0, 0, 5, 5, 5, 5, 9, 9});
        // T junction
        send_pair(1'b0, '{-5, 0, 5, 0, 0, 0, 0, 7});
        send_pair(1'b1, '{-5, 0, 5, 0, 0, 0, 0, 7});
        // point segments
        send_pair(1'b0, '{3, 3, 3, 3, 0, 0, 6, 6});
        send_pair(1'b1, '{3, 3, 3, 3, 0, 0, 6, 6});
        send_pair(1'b0, '{3, 4, 3, 4, 0, 0, 6, 6});
        send_pair(1'b0, '{7, -7, 7, -7, 7, -7, 7, -7});
        send_pair(1'b1, '{7, -7, 7, -7, 7, -7, 7, -7});
        send_pair(1'b0, '{7, -7, 7, -7, 7, -6, 7, -6});
        // every coordinate at one extreme
        send_pair(1'b0, '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
        send_pair(1'b1, '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768});
        // long collinear diagonal with a short piece inside
        send_pair(1'b1, '{-32768, -32768, 32767, 32767, -1, -1, 0, 0});
        send_pair(1'b0, '{-32768, -32768, 32767, 32767, -1, -1, 0, 0});
        // lines cross beyond the end of one segment
        send_pair(1'b0, '{0, 0, 4, 4, 10, 0, 0, 10});
        directed_pairs = pairs_sent;

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            quiet = (n >= 400 && n < 500) || (n >= RANDOM_PAIRS - QUIET_TAIL);
            send_random_pair();
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d segment pairs (%0d directed), %0d results checked, %0d hits.",
                 pairs_sent, directed_pairs, checked, hits);
        $display("Both modes, crossings, touches, collinear and point segments, with stalls.");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
